// File: src/itt_pkg.sv
// Package for the 3x3 inverse transpose unit.
// Holds widths, operand tables and pipeline types; no dependencies.
package itt_pkg;

    localparam int N_ENT   = 9;
    localparam int N_PROD  = 18;
    localparam int ENT_W   = 32;
    localparam int COF_W   = 64;
    localparam int DET_W   = 98;
    localparam int REM_W   = 97;
    localparam int NUM_W   = 128;
    localparam int N_DIV   = 32;
    localparam int DATA_W  = N_ENT * ENT_W;
    localparam int USER_W  = 2;

    localparam logic [ENT_W-1:0] LIM_POS = 32'h7fff_ffff;
    localparam logic [ENT_W-1:0] LIM_NEG = 32'h8000_0000;

    typedef logic [3:0] idx_t;

    // Product operands; cofactor k is product 2k minus product 2k+1.
    localparam idx_t OPA [N_PROD] = '{4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd4, 4'd2, 4'd1, 4'd0,
                                      4'd2, 4'd1, 4'd0, 4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd1};
    localparam idx_t OPB [N_PROD] = '{4'd8, 4'd7, 4'd6, 4'd8, 4'd7, 4'd6, 4'd7, 4'd8, 4'd8,
                                      4'd6, 4'd6, 4'd7, 4'd5, 4'd4, 4'd3, 4'd5, 4'd4, 4'd3};

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [31:0]      lo;
        logic [31:0]      q;
        logic             ovf;
        logic             neg;
    } lane_t;

    typedef struct packed {
        lane_t [N_ENT-1:0] lane;
        logic [REM_W-1:0]  dmag;
        logic              zero;
    } div_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [USER_W-1:0] user;
    } res_t;

endpackage

// File: src/inverse_transpose_3x3_unit.sv
// Top level of the 3x3 inverse transpose unit.
// Depends on itt_pkg for widths, operand tables and stage types.
//
// Streams one 3x3 Q matrix per cycle while s_tready is high and returns the transpose
// of its inverse with singular and saturated flags. The pipeline is six stages of
// products, cofactors, determinant partial products, sums and magnitudes, then a
// 33-stage restoring divider per entry (setup, then one quotient bit per stage),
// then the saturating output register. Throughput is one transaction per cycle while
// s_tready is high, set by the fully pipelined divider lanes; a two-entry output
// buffer keeps s_tready registered while m_tready is low.
module inverse_transpose_3x3_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (32 bits each)
    input  logic [itt_pkg::DATA_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 (32 bits each)
    output logic [itt_pkg::DATA_W-1:0] m_tdata,
    // singular, saturated
    output logic [itt_pkg::USER_W-1:0] m_tuser
);
    import itt_pkg::*;

    logic en;

    logic signed [ENT_W-1:0]   m_in [N_ENT];
    logic signed [COF_W-1:0]   prod_reg [N_PROD];
    logic signed [ENT_W-1:0]   abc1_reg [3];
    logic                      v1_reg;

    logic signed [COF_W-1:0]   cof2_reg [N_ENT];
    logic signed [ENT_W-1:0]   abc2_reg [3];
    logic                      v2_reg;

    logic signed [COF_W-1:0]   cof3_reg [N_ENT];
    logic signed [COF_W-1:0]   ph_reg [3];
    logic signed [COF_W:0]     pl_reg [3];
    logic                      v3_reg;

    logic signed [COF_W-1:0]   cof4_reg [N_ENT];
    logic signed [DET_W-1:0]   term_reg [3];
    logic                      v4_reg;

    logic signed [COF_W-1:0]   cof5_reg [N_ENT];
    logic signed [DET_W-1:0]   det_reg;
    logic                      v5_reg;

    logic [COF_W-1:0]          cm_reg [N_ENT];
    logic [N_ENT-1:0]          cneg_reg;
    logic [REM_W-1:0]          dmag_reg;
    logic                      zero_reg;
    logic                      v6_reg;

    div_t                      div_reg [N_DIV+1];
    logic [N_DIV:0]            div_v_reg;
    div_t                      div_next [N_DIV+1];
    div_t                      init_next;

    res_t                      fin_next;
    res_t                      out_reg;
    res_t                      skid_reg;
    logic                      out_v_reg;
    logic                      skid_v_reg;
    logic                      fin_v;

    function automatic lane_t div_step(lane_t l, logic [REM_W-1:0] dmag);
        logic [REM_W:0] t;
        logic [REM_W:0] diff;
        lane_t          r;
        t    = {l.rem, l.lo[31]};
        diff = t - {1'b0, dmag};
        r    = l;
        r.lo = {l.lo[30:0], 1'b0};
        if (t >= {1'b0, dmag})
        begin
            r.rem = diff[REM_W-1:0];
            r.q   = {l.q[30:0], 1'b1};
        end
        else
        begin
            r.rem = t[REM_W-1:0];
            r.q   = {l.q[30:0], 1'b0};
        end
        return r;
    endfunction

    assign en       = !skid_v_reg;
    assign s_tready = en;

    always_comb
    begin
        for (int k = 0; k < N_ENT; k++)
        begin
            m_in[k] = s_tdata[k*ENT_W +: ENT_W];
        end
    end

    always_comb
    begin
        logic [NUM_W-1:0] num;
        init_next.dmag = dmag_reg;
        init_next.zero = zero_reg;
        for (int k = 0; k < N_ENT; k++)
        begin
            num = {{(NUM_W-COF_W){1'b0}}, cm_reg[k]} << (2 * FRAC_BITS);
            init_next.lane[k].rem = {1'b0, num[NUM_W-1:32]};
            init_next.lane[k].lo  = num[31:0];
            init_next.lane[k].q   = '0;
            init_next.lane[k].ovf = {1'b0, num[NUM_W-1:32]} >= dmag_reg;
            init_next.lane[k].neg = cneg_reg[k];
        end
    end

    always_comb
    begin
        div_next[0] = init_next;
        for (int s = 1; s <= N_DIV; s++)
        begin
            div_next[s] = div_reg[s-1];
            for (int k = 0; k < N_ENT; k++)
            begin
                div_next[s].lane[k] = div_step(div_reg[s-1].lane[k], div_reg[s-1].dmag);
            end
        end
    end

    always_comb
    begin
        logic [ENT_W-1:0] lim;
        logic [ENT_W-1:0] mag;
        logic             sat;
        logic             any_sat;
        any_sat = 1'b0;
        fin_next.data = '0;
        for (int k = 0; k < N_ENT; k++)
        begin
            lim = div_reg[N_DIV].lane[k].neg ? LIM_NEG : LIM_POS;
            sat = div_reg[N_DIV].lane[k].ovf || (div_reg[N_DIV].lane[k].q > lim);
            mag = sat ? lim : div_reg[N_DIV].lane[k].q;
            any_sat = any_sat | sat;
            fin_next.data[k*ENT_W +: ENT_W] = div_reg[N_DIV].lane[k].neg ? (~mag + 1'b1) : mag;
        end
        if (div_reg[N_DIV].zero)
        begin
            fin_next.data = '0;
            fin_next.user = 2'b01;
        end
        else
        begin
            fin_next.user = {any_sat, 1'b0};
        end
    end

    assign fin_v = en && div_v_reg[N_DIV];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            v5_reg     <= 1'b0;
            v6_reg     <= 1'b0;
            div_v_reg  <= '0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v1_reg    <= s_tvalid;
                v2_reg    <= v1_reg;
                v3_reg    <= v2_reg;
                v4_reg    <= v3_reg;
                v5_reg    <= v4_reg;
                v6_reg    <= v5_reg;
                div_v_reg <= {div_v_reg[N_DIV-1:0], v6_reg};
            end
            if (m_tready || !out_v_reg)
            begin
                if (skid_v_reg)
                begin
                    skid_v_reg <= 1'b0;
                end
                else
                begin
                    out_v_reg <= fin_v;
                end
            end
            else if (fin_v)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int p = 0; p < N_PROD; p++)
            begin
                prod_reg[p] <= m_in[OPA[p]] * m_in[OPB[p]];
            end
            for (int j = 0; j < 3; j++)
            begin
                abc1_reg[j] <= m_in[j];
                abc2_reg[j] <= abc1_reg[j];
                ph_reg[j]   <= abc2_reg[j] * $signed(cof2_reg[j][COF_W-1:32]);
                pl_reg[j]   <= abc2_reg[j] * $signed({1'b0, cof2_reg[j][31:0]});
                term_reg[j] <= $signed({{2{ph_reg[j][COF_W-1]}}, ph_reg[j], 32'd0})
                             + $signed({{(DET_W-COF_W-1){pl_reg[j][COF_W]}}, pl_reg[j]});
            end
            for (int k = 0; k < N_ENT; k++)
            begin
                cof2_reg[k] <= prod_reg[2*k] - prod_reg[2*k+1];
                cof3_reg[k] <= cof2_reg[k];
                cof4_reg[k] <= cof3_reg[k];
                cof5_reg[k] <= cof4_reg[k];
                cm_reg[k]   <= cof5_reg[k][COF_W-1] ? (~cof5_reg[k] + 1'b1) : cof5_reg[k];
                cneg_reg[k] <= cof5_reg[k][COF_W-1] ^ det_reg[DET_W-1];
            end
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            dmag_reg <= det_reg[DET_W-1] ? REM_W'(~det_reg + 1'b1) : det_reg[REM_W-1:0];
            zero_reg <= (det_reg == '0);
            for (int s = 0; s <= N_DIV; s++)
            begin
                div_reg[s] <= div_next[s];
            end
        end
        if (m_tready || !out_v_reg)
        begin
            out_reg <= skid_v_reg ? skid_reg : fin_next;
        end
        else if (fin_v)
        begin
            skid_reg <= fin_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.user;

endmodule

// File: src/itt_checker.sv
// Port-level checker for the 3x3 inverse transpose unit, with its bind.
// Depends on itt_pkg for port widths.
module itt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [itt_pkg::DATA_W-1:0] m_tdata,
    input logic [itt_pkg::USER_W-1:0] m_tuser
);
    import itt_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("singular result not cleared");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

endmodule

bind inverse_transpose_3x3_unit itt_checker u_itt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
